>>> rtl/slxfp_pkg.sv
// ----------------------------------------------------------------------------
// slxfp_pkg
// Shared types and constants of the sync/length/XOR frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package slxfp_pkg;

	localparam int unsigned MAX_POSITION_DEF = 32;
	localparam int unsigned FRONT_OVERHEAD   = 3;
	localparam int unsigned BYTE_W           = 8;
	localparam int unsigned LEN_CMP_W        = 9;
	localparam logic [BYTE_W-1:0] SYNC_RESET = 8'd164;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_END     = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_CSUM_FAIL = 2'd1,
		ST_SIZE      = 2'd2
	} frame_status_t;

	typedef struct packed {
		logic              item_kind;
		logic [BYTE_W-1:0] payload_index;
		logic [BYTE_W-1:0] payload_value;
		frame_status_t     frame_status;
		logic [BYTE_W-1:0] frame_length;
		logic [BYTE_W-1:0] message_id;
		logic              last_of_frame;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/slxfp_if.sv
// ----------------------------------------------------------------------------
// slxfp_if
// Valid/ready channels of the frame parser: received bytes, results, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface slxfp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slxfp_out_if;
	logic       valid;
	logic       ready;
	logic       item_kind;
	logic [7:0] payload_index;
	logic [7:0] payload_value;
	logic [1:0] frame_status;
	logic [7:0] frame_length;
	logic [7:0] message_id;
	logic       last_of_frame;

	modport source (
		output valid, output item_kind, output payload_index, output payload_value,
		output frame_status, output frame_length, output message_id,
		output last_of_frame, input ready
	);
	modport sink (
		input valid, input item_kind, input payload_index, input payload_value,
		input frame_status, input frame_length, input message_id,
		input last_of_frame, output ready
	);
endinterface

interface slxfp_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] sync_value;

	modport source (output valid, output sync_value, input ready);
	modport sink   (input valid, input sync_value, output ready);
endinterface

`default_nettype wire

>>> rtl/sync_length_xor_frame_parser_top.sv
// ----------------------------------------------------------------------------
// sync_length_xor_frame_parser_top
// Byte-stream deframer: sync, length, message id, payload, XOR checksum.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                    | request when
//  rx      | in  | rx_byte                                    | valid & ready
//  result  | out | kind, index, value, status, length, id, last | valid & ready
//  cfg     | in  | sync_value                                 | valid & ready
//
//  One byte per cycle while no stalled result holds it: a byte is held in
//  the input register, parsed by the core and its result loaded into the
//  output register.
//  A stalled result only blocks a byte that would produce another result.
//  Reset restores sync_value 164 and clears the frame state.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_length_xor_frame_parser_top #(
	parameter int unsigned MAX_POSITION = slxfp_pkg::MAX_POSITION_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	slxfp_in_if.sink      rx,
	slxfp_out_if.source   result,
	slxfp_cfg_if.sink     cfg
);
	import slxfp_pkg::*;

	logic [BYTE_W-1:0] sync_q;
	logic              byte_valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_valid_q;
	result_t           out_q;
	logic              core_res_valid;
	result_t           core_res;
	logic              advance;
	logic              load;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= SYNC_RESET;
		end else if (cfg.valid) begin
			sync_q <= cfg.sync_value;
		end
	end

	assign advance  = byte_valid_s1 && (!core_res_valid || !out_valid_q || result.ready);
	assign load     = advance && core_res_valid;
	assign rx.ready = !byte_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			byte_valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	slxfp_core #(
		.MAX_POSITION (MAX_POSITION)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.rx_byte    (byte_s1),
		.sync_value (sync_q),
		.res_valid  (core_res_valid),
		.res        (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= core_res;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.item_kind     = out_q.item_kind;
	assign result.payload_index = out_q.payload_index;
	assign result.payload_value = out_q.payload_value;
	assign result.frame_status  = out_q.frame_status;
	assign result.frame_length  = out_q.frame_length;
	assign result.message_id    = out_q.message_id;
	assign result.last_of_frame = out_q.last_of_frame;

endmodule

`default_nettype wire

>>> rtl/slxfp_core.sv
// ----------------------------------------------------------------------------
// slxfp_core
// Frame state (position, running XOR, length, message id) and the per-byte
// parse step that yields at most one result.
// ----------------------------------------------------------------------------
`default_nettype none

module slxfp_core #(
	parameter int unsigned MAX_POSITION = slxfp_pkg::MAX_POSITION_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire logic [7:0]           rx_byte,
	input  wire logic [7:0]           sync_value,
	output logic                      res_valid,
	output slxfp_pkg::result_t        res
);
	import slxfp_pkg::*;

	localparam int unsigned POS_W = $clog2(MAX_POSITION + 2);
	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_POSITION);
	localparam logic [POS_W-1:0] POS_HEAD  = POS_W'(FRONT_OVERHEAD);

	logic [POS_W-1:0]  pos_q, pos_d;
	logic [BYTE_W-1:0] xor_q, xor_d;
	logic [BYTE_W-1:0] len_q, len_d;
	logic [BYTE_W-1:0] id_q, id_d;
	logic [BYTE_W-1:0] xor_next;
	logic              at_end;

	assign xor_next = xor_q ^ rx_byte;
	assign at_end   = (LEN_CMP_W'(pos_q) == (LEN_CMP_W'(len_q) + LEN_CMP_W'(FRONT_OVERHEAD)));

	always_comb begin
		pos_d     = pos_q;
		xor_d     = xor_next;
		len_d     = len_q;
		id_d      = id_q;
		res_valid = 1'b0;
		res       = '{
			item_kind:     KIND_PAYLOAD,
			payload_index: '0,
			payload_value: rx_byte,
			frame_status:  ST_OK,
			frame_length:  len_q,
			message_id:    id_q,
			last_of_frame: 1'b0
		};
		priority if (pos_q == '0) begin
			xor_d = xor_q;
			if (rx_byte == sync_value) begin
				xor_d = rx_byte;
				pos_d = POS_W'(1);
			end
		end else if (pos_q == POS_W'(1)) begin
			len_d = rx_byte;
			pos_d = POS_W'(2);
		end else if (pos_q == POS_W'(2)) begin
			id_d  = rx_byte;
			pos_d = POS_HEAD;
		end else if (pos_q > POS_LIMIT) begin
			res_valid         = 1'b1;
			res.item_kind     = KIND_END;
			res.last_of_frame = 1'b1;
			res.frame_status  = ST_SIZE;
			pos_d             = '0;
			xor_d             = '0;
		end else if (at_end) begin
			res_valid         = 1'b1;
			res.item_kind     = KIND_END;
			res.last_of_frame = 1'b1;
			res.frame_status  = (xor_next == '0) ? ST_OK : ST_CSUM_FAIL;
			pos_d             = '0;
			xor_d             = '0;
		end else begin
			res_valid         = 1'b1;
			res.payload_index = BYTE_W'(pos_q - POS_HEAD);
			pos_d             = pos_q + POS_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			xor_q <= '0;
			len_q <= '0;
			id_q  <= '0;
		end else if (step) begin
			pos_q <= pos_d;
			xor_q <= xor_d;
			len_q <= len_d;
			id_q  <= id_d;
		end
	end

endmodule

`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Frame parser testbench: feeds received bytes over valid/ready, predicts
// payload and frame end results in step with accepted requests, and checks
// every result in order; in the first two phases both sides idle at random.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import slxfp_pkg::*;

	localparam int unsigned MAX_POS     = MAX_POSITION_DEF;
	localparam int          CYCLE_LIMIT = 400000;
	localparam int          SETTLE      = 6;

	typedef logic [7:0] byte_q_t[$];
	typedef struct {
		logic [7:0] b;
		bit         drain;
	} rx_req_t;

	logic clk = 1'b0;
	logic arst_n;

	slxfp_in_if  rx ();
	slxfp_out_if result ();
	slxfp_cfg_if cfg ();

	sync_length_xor_frame_parser_top #(.MAX_POSITION(MAX_POS)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.result (result),
		.cfg    (cfg)
	);

	always #10 clk = ~clk;

	rx_req_t    rx_pending[$];
	result_t    frame_expect[$];
	int         rx_next = 0;
	int         rx_sent = 0;
	int         rx_taken = 0;
	int         errors = 0;
	int         cycles = 0;
	int         send_gap_pct = 21;
	int         take_stall_pct = 80;

	logic [7:0] sync_reg = SYNC_RESET;
	int         frame_pos = 0;
	logic [7:0] frame_xor = '0;
	logic [7:0] hold_len = '0;
	logic [7:0] hold_id = '0;

	function automatic bit parse_byte(input logic [7:0] b, output result_t r);
		r = '0;
		if (frame_pos == 0) begin
			if (b == sync_reg) begin
				frame_xor = b;
				frame_pos = 1;
			end
			return 1'b0;
		end
		frame_xor = frame_xor ^ b;
		if (frame_pos == 1) begin
			hold_len = b;
			frame_pos = 2;
			return 1'b0;
		end
		if (frame_pos == 2) begin
			hold_id = b;
			frame_pos = 3;
			return 1'b0;
		end
		r.frame_length = hold_len;
		r.message_id = hold_id;
		r.payload_value = b;
		if (frame_pos > MAX_POS || frame_pos == int'(hold_len) + int'(FRONT_OVERHEAD)) begin
			r.item_kind = KIND_END;
			r.last_of_frame = 1'b1;
			if (frame_pos > MAX_POS)
				r.frame_status = ST_SIZE;
			else
				r.frame_status = (frame_xor == 8'h00) ? ST_OK : ST_CSUM_FAIL;
			frame_pos = 0;
			frame_xor = '0;
		end else begin
			r.item_kind = KIND_PAYLOAD;
			r.payload_index = 8'(frame_pos - int'(FRONT_OVERHEAD));
			frame_pos = frame_pos + 1;
		end
		return 1'b1;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		result_t got;
		result_t want;
		result_t pred;
		if (arst_n) begin
			cycles++;
			if (result.valid && result.ready) begin
				got.item_kind = result.item_kind;
				got.payload_index = result.payload_index;
				got.payload_value = result.payload_value;
				got.frame_status = frame_status_t'(result.frame_status);
				got.frame_length = result.frame_length;
				got.message_id = result.message_id;
				got.last_of_frame = result.last_of_frame;
				if (frame_expect.size() == 0) begin
					$display("%0t: result expected none actual kind %0h index %0h value %0h",
						$time, got.item_kind, got.payload_index, got.payload_value);
					errors++;
				end else begin
					want = frame_expect.pop_front();
					check_field("item_kind", 8'(want.item_kind), 8'(got.item_kind));
					check_field("payload_index", want.payload_index, got.payload_index);
					check_field("payload_value", want.payload_value, got.payload_value);
					check_field("frame_status", 8'(want.frame_status), 8'(got.frame_status));
					check_field("frame_length", want.frame_length, got.frame_length);
					check_field("message_id", want.message_id, got.message_id);
					check_field("last_of_frame", 8'(want.last_of_frame), 8'(got.last_of_frame));
				end
			end
			if (rx.valid && rx.ready) begin
				rx_taken++;
				if (parse_byte(rx.rx_byte, pred))
					frame_expect.push_back(pred);
			end
			if (cfg.valid && cfg.ready)
				sync_reg = cfg.sync_value;
			if (cycles > CYCLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (rx_sent == rx_taken) begin
				if (rx_next < rx_pending.size()
						&& !(rx_pending[rx_next].drain && frame_expect.size() != 0)
						&& $urandom_range(99) >= send_gap_pct) begin
					rx.valid <= 1'b1;
					rx.rx_byte <= rx_pending[rx_next].b;
					rx_next++;
					rx_sent++;
				end else begin
					rx.valid <= 1'b0;
					rx.rx_byte <= 8'($urandom);
				end
			end
			result.ready <= ($urandom_range(99) >= take_stall_pct);
		end
	end

	task automatic push_byte(input logic [7:0] b, input bit drain);
		rx_req_t req;
		req.b = b;
		req.drain = drain;
		rx_pending.push_back(req);
	endtask

	task automatic push_frame(input logic [7:0] sync_b, input logic [7:0] len,
			input logic [7:0] id, input byte_q_t body, input logic [7:0] csum_flip,
			input bit tail, input bit drain);
		logic [7:0] x;
		x = sync_b ^ len ^ id;
		push_byte(sync_b, drain);
		push_byte(len, 1'b0);
		push_byte(id, 1'b0);
		foreach (body[i]) begin
			x = x ^ body[i];
			push_byte(body[i], 1'b0);
		end
		if (tail)
			push_byte(x ^ csum_flip, 1'b0);
	endtask

	task automatic push_random_frame(input logic [7:0] sync_b, input bit drain);
		byte_q_t    body;
		logic [7:0] len;
		logic [7:0] flip;
		int         sel;
		int         n;
		bit         tail;
		sel = $urandom_range(99);
		if (sel < 55)
			len = 8'($urandom_range(0, 8));
		else if (sel < 70)
			len = 8'($urandom_range(9, 24));
		else if (sel < 80)
			len = 8'($urandom_range(25, 29));
		else if (sel < 90)
			len = 8'($urandom_range(30, 33));
		else
			len = 8'($urandom_range(34, 255));
		n = (len > 29) ? 30 + $urandom_range(0, 2) : int'(len);
		for (int i = 0; i < n; i++)
			body.push_back(($urandom_range(9) == 0) ? sync_b : 8'($urandom));
		flip = ($urandom_range(3) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
		tail = ($urandom_range(19) != 0);
		if (!tail && body.size() > 0 && $urandom_range(1) == 0)
			void'(body.pop_back());
		push_frame(sync_b, len, 8'($urandom), body, flip, tail, drain);
	endtask

	task automatic run_frames(input logic [7:0] sync_b, input int n_items, input bit pause);
		int start;
		bit paused;
		start = rx_pending.size();
		paused = 1'b0;
		while (rx_pending.size() - start < n_items) begin
			if ($urandom_range(99) < 15)
				repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0);
			if (pause && !paused && rx_pending.size() - start >= n_items / 2) begin
				push_random_frame(sync_b, 1'b1);
				paused = 1'b1;
			end else begin
				push_random_frame(sync_b, 1'b0);
			end
		end
	endtask

	task automatic wait_idle();
		while (rx_next < rx_pending.size() || rx_sent != rx_taken || frame_expect.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_sync(input logic [7:0] v);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.sync_value <= v;
		do @(posedge clk); while (!(cfg.valid && cfg.ready));
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	initial begin
		byte_q_t    body;
		logic [7:0] next_sync;
		arst_n = 1'b0;
		rx.valid = 1'b0;
		rx.rx_byte = '0;
		result.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.sync_value = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h5A, 1'b0);
		body = {};
		push_frame(SYNC_RESET, 8'd0, 8'hFF, body, 8'h00, 1'b1, 1'b0);
		body = {8'hFF};
		push_frame(SYNC_RESET, 8'd1, 8'h00, body, 8'h80, 1'b1, 1'b0);
		body = {8'h00, SYNC_RESET};
		push_frame(SYNC_RESET, 8'd2, 8'h80, body, 8'h00, 1'b1, 1'b0);
		run_frames(SYNC_RESET, 130, 1'b0);
		wait_idle();

		write_sync(8'h00);
		send_gap_pct = 80;
		take_stall_pct = 21;
		run_frames(8'h00, 130, 1'b1);
		wait_idle();

		write_sync(8'hFF);
		send_gap_pct = 0;
		take_stall_pct = 0;
		run_frames(8'hFF, 130, 1'b0);
		wait_idle();

		next_sync = 8'($urandom);
		write_sync(next_sync);
		run_frames(next_sync, 130, 1'b0);
		wait_idle();

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
